>>> rtl/core/krc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krc_pkg
// Types and constants shared by the knock retard controller files.
// ----------------------------------------------------------------------------
package krc_pkg;

  localparam int CYL_W     = 2;
  localparam int RETARD_W  = 8;
  localparam int COUNT_W   = 8;
  localparam int THRESH_W  = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 12'd2048;
  localparam logic [THRESH_W-1:0] THRESHOLD_MAX   = 12'd4095;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 8'd255;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_PULSE = 2'd2,
    OP_CYCLE = 2'd3
  } krc_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_LIMIT     = 3'd0,
    REG_RETARD_STEP     = 3'd1,
    REG_RETARD_LIMIT    = 3'd2,
    REG_RECOVERY_STEP   = 3'd3,
    REG_RECOVERY_DELAY  = 3'd4,
    REG_THR_KNOCK_STEP  = 3'd5,
    REG_THR_CLEAN_STEP  = 3'd6,
    REG_CLEAN_LIMIT     = 3'd7
  } krc_reg_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [CYL_W-1:0] cylinder;
  } krc_in_t;

  typedef struct packed {
    logic [RETARD_W-1:0] retard_tenths;
    logic [THRESH_W-1:0] detector_threshold;
    logic                threshold_written;
    logic                window_is_open;
    logic [COUNT_W-1:0]  pulse_count;
  } krc_out_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  pulse_limit;
    logic [RETARD_W-1:0] retard_step;
    logic [RETARD_W-1:0] retard_limit;
    logic [RETARD_W-1:0] recovery_step;
    logic [COUNT_W-1:0]  recovery_delay;
    logic [THRESH_W-1:0] threshold_knock_step;
    logic [THRESH_W-1:0] threshold_clean_step;
    logic [COUNT_W-1:0]  clean_cycles_limit;
  } krc_cfg_t;

  // state of one cylinder plus the shared counters, as seen by the cycle unit
  typedef struct packed {
    logic [COUNT_W-1:0]  pulse;
    logic [COUNT_W-1:0]  clean;
    logic [RETARD_W-1:0] retard;
    logic [COUNT_W-1:0]  global_clean;
    logic [THRESH_W-1:0] threshold;
  } krc_cyc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  clean;
    logic [RETARD_W-1:0] retard;
    logic [COUNT_W-1:0]  global_clean;
    logic [THRESH_W-1:0] threshold;
    logic                wrote;
  } krc_cyc_out_t;

endpackage

>>> rtl/core/krc_cycle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krc_cycle_unit
// End-of-cycle update for one cylinder: knock retard, clean-run recovery and
// detector threshold adjustment.
// ----------------------------------------------------------------------------
module krc_cycle_unit
  import krc_pkg::*;
(
  input  krc_cfg_t     cfg,
  input  krc_cyc_in_t  cur,
  output krc_cyc_out_t upd
);

  logic                knock;
  logic [RETARD_W:0]   retard_sum;
  logic [COUNT_W-1:0]  clean_inc;
  logic [COUNT_W-1:0]  global_inc;
  logic [THRESH_W-1:0] thr_room;

  assign knock      = cur.pulse > cfg.pulse_limit;
  assign retard_sum = {1'b0, cur.retard} + {1'b0, cfg.retard_step};
  assign clean_inc  = (cur.clean < COUNT_MAX) ? cur.clean + 8'd1 : cur.clean;
  assign global_inc = (cur.global_clean < COUNT_MAX) ? cur.global_clean + 8'd1
                                                     : cur.global_clean;
  assign thr_room   = THRESHOLD_MAX - cfg.threshold_clean_step;

  always_comb begin
    upd.clean        = cur.clean;
    upd.retard       = cur.retard;
    upd.global_clean = cur.global_clean;
    upd.threshold    = cur.threshold;
    upd.wrote        = 1'b0;
    if (knock) begin
      upd.retard       = (retard_sum > {1'b0, cfg.retard_limit}) ? cfg.retard_limit
                                                                 : retard_sum[RETARD_W-1:0];
      upd.clean        = '0;
      upd.global_clean = '0;
      upd.threshold    = (cur.threshold >= cfg.threshold_knock_step)
                         ? cur.threshold - cfg.threshold_knock_step : '0;
      upd.wrote        = 1'b1;
    end else begin
      upd.clean = clean_inc;
      if (clean_inc >= cfg.recovery_delay && cur.retard >= cfg.recovery_step) begin
        upd.retard = cur.retard - cfg.recovery_step;
      end
      upd.global_clean = global_inc;
      if (global_inc >= cfg.clean_cycles_limit) begin
        upd.threshold    = (cur.threshold <= thr_room)
                           ? cur.threshold + cfg.threshold_clean_step : THRESHOLD_MAX;
        upd.wrote        = 1'b1;
        upd.global_clean = '0;
      end
    end
  end

endmodule

>>> rtl/core/knock_retard_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knock_retard_controller
// Per-cylinder knock detection window, pulse counting and ignition retard.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  (op, cylinder) beats arrive on in_valid/in_ready. Each beat gives
//   exactly one out_item beat on out_valid/out_ready, in order.
//   cfg_write/cfg_index/cfg_data write one of eight tuning registers;
//   write them only while no beat is in flight.
// Path: an accepted beat waits in the input register; when the output register
//   can load, it is applied to the cylinder state and its result is registered
//   into out_item.
// Throughput: one beat per clock while out_ready is high. All state is a few small
//   registers updated by one pass of compare/add logic, so the input register
//   feeds the result register every cycle unless the output stalls.
// Stall: when out_ready is low the result holds; the input register keeps
//   one more beat, then in_ready drops until the result is taken.
// Reset (rst, synchronous): counters and retard clear, detector threshold
//   goes to 2048, window closes, registers return to defaults, no beat is
//   held.
// ----------------------------------------------------------------------------
module knock_retard_controller
  import krc_pkg::*;
#(
  parameter int CYLINDERS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  krc_in_t              in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output krc_out_t             out_item,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [CYL_W:0] CYL_COUNT = (CYL_W + 1)'(CYLINDERS);

  krc_cfg_t cfg;

  logic    s1_valid;
  krc_in_t s1_item;
  logic    out_load;
  logic    advance;

  logic [COUNT_W-1:0]  pulse  [CYLINDERS];
  logic [COUNT_W-1:0]  clean  [CYLINDERS];
  logic [RETARD_W-1:0] retard [CYLINDERS];
  logic [COUNT_W-1:0]  global_clean;
  logic [THRESH_W-1:0] threshold;
  logic [CYL_W-1:0]    window_sel;
  logic                window_flag;

  logic [COUNT_W-1:0]  pulse_next  [CYLINDERS];
  logic [COUNT_W-1:0]  clean_next  [CYLINDERS];
  logic [RETARD_W-1:0] retard_next [CYLINDERS];
  logic [COUNT_W-1:0]  global_clean_next;
  logic [THRESH_W-1:0] threshold_next;
  logic [CYL_W-1:0]    window_sel_next;
  logic                window_flag_next;

  krc_op_e      op;
  logic         present;
  krc_cyc_in_t  cyc_cur;
  krc_cyc_out_t cyc_upd;
  krc_out_t     result;

  assign out_load = !out_valid || out_ready;
  assign advance  = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  assign op      = krc_op_e'(s1_item.op);
  assign present = {1'b0, s1_item.cylinder} < CYL_COUNT;

  // selected cylinder state into the cycle unit
  always_comb begin
    cyc_cur.pulse        = '0;
    cyc_cur.clean        = '0;
    cyc_cur.retard       = '0;
    cyc_cur.global_clean = global_clean;
    cyc_cur.threshold    = threshold;
    for (int i = 0; i < CYLINDERS; i++) begin
      if (s1_item.cylinder == CYL_W'(i)) begin
        cyc_cur.pulse  = pulse[i];
        cyc_cur.clean  = clean[i];
        cyc_cur.retard = retard[i];
      end
    end
  end

  krc_cycle_unit u_cycle (
    .cfg (cfg),
    .cur (cyc_cur),
    .upd (cyc_upd)
  );

  always_comb begin
    pulse_next        = pulse;
    clean_next        = clean;
    retard_next       = retard;
    global_clean_next = global_clean;
    threshold_next    = threshold;
    window_sel_next   = window_sel;
    window_flag_next  = window_flag;
    result.threshold_written = 1'b0;
    case (op)
      OP_OPEN: begin
        if (present) begin
          window_sel_next  = s1_item.cylinder;
          window_flag_next = 1'b1;
        end
      end
      OP_CLOSE: begin
        if (present && window_flag && window_sel == s1_item.cylinder) begin
          window_flag_next = 1'b0;
        end
      end
      OP_PULSE: begin
        // counts against the open window's cylinder, not the beat's
        if (window_flag) begin
          for (int i = 0; i < CYLINDERS; i++) begin
            if (window_sel == CYL_W'(i) && pulse[i] < COUNT_MAX) begin
              pulse_next[i] = pulse[i] + 8'd1;
            end
          end
        end
      end
      default: begin
        if (present) begin
          for (int i = 0; i < CYLINDERS; i++) begin
            if (s1_item.cylinder == CYL_W'(i)) begin
              pulse_next[i]  = '0;
              clean_next[i]  = cyc_upd.clean;
              retard_next[i] = cyc_upd.retard;
            end
          end
          global_clean_next        = cyc_upd.global_clean;
          threshold_next           = cyc_upd.threshold;
          result.threshold_written = cyc_upd.wrote;
        end
      end
    endcase

    // missing cylinders report zero
    result.retard_tenths = '0;
    result.pulse_count   = '0;
    for (int i = 0; i < CYLINDERS; i++) begin
      if (s1_item.cylinder == CYL_W'(i)) begin
        result.retard_tenths = retard_next[i];
        result.pulse_count   = pulse_next[i];
      end
    end
    result.detector_threshold = threshold_next;
    result.window_is_open     = window_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      global_clean <= '0;
      threshold    <= THRESHOLD_RESET;
      window_sel   <= '0;
      window_flag  <= 1'b0;
      for (int i = 0; i < CYLINDERS; i++) begin
        pulse[i]  <= '0;
        clean[i]  <= '0;
        retard[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_load) begin
        out_valid <= s1_valid;
      end
      if (advance) begin
        pulse        <= pulse_next;
        clean        <= clean_next;
        retard       <= retard_next;
        global_clean <= global_clean_next;
        threshold    <= threshold_next;
        window_sel   <= window_sel_next;
        window_flag  <= window_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_limit          <= 8'd3;
      cfg.retard_step          <= 8'd20;
      cfg.retard_limit         <= 8'd100;
      cfg.recovery_step        <= 8'd1;
      cfg.recovery_delay       <= 8'd10;
      cfg.threshold_knock_step <= 12'd130;
      cfg.threshold_clean_step <= 12'd65;
      cfg.clean_cycles_limit   <= 8'd100;
    end else if (cfg_write) begin
      unique case (krc_reg_e'(cfg_index))
        REG_PULSE_LIMIT:     cfg.pulse_limit          <= cfg_data[COUNT_W-1:0];
        REG_RETARD_STEP:     cfg.retard_step          <= cfg_data[RETARD_W-1:0];
        REG_RETARD_LIMIT:    cfg.retard_limit         <= cfg_data[RETARD_W-1:0];
        REG_RECOVERY_STEP:   cfg.recovery_step        <= cfg_data[RETARD_W-1:0];
        REG_RECOVERY_DELAY:  cfg.recovery_delay       <= cfg_data[COUNT_W-1:0];
        REG_THR_KNOCK_STEP:  cfg.threshold_knock_step <= cfg_data[THRESH_W-1:0];
        REG_THR_CLEAN_STEP:  cfg.threshold_clean_step <= cfg_data[THRESH_W-1:0];
        REG_CLEAN_LIMIT:     cfg.clean_cycles_limit   <= cfg_data[COUNT_W-1:0];
      endcase
    end
  end

endmodule

>>> rtl/core/krc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krc_checker
// Port-level checks for the knock retard controller, bound to the top level.
// ----------------------------------------------------------------------------
module krc_checker
  import krc_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input krc_out_t out_item
);

  // threshold of the last delivered result beat
  logic [THRESH_W-1:0] last_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_thr <= THRESHOLD_RESET;
    end else if (out_valid && out_ready) begin
      last_thr <= out_item.detector_threshold;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat offered after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_thr_only_on_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.threshold_written |-> out_item.detector_threshold == last_thr)
    else $error("threshold moved without a write");

endmodule

bind knock_retard_controller krc_checker u_krc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
